### design/mwfl_pkg.sv
`default_nettype none

package mwfl_pkg;

  localparam int HISTORY_DEPTH = 32;
  localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int NUM_RULES     = 3;
  localparam int COUNT_W       = 8;
  localparam int TIME_W        = 31;
  localparam int STAMP_W       = 32;

  localparam int RULE_A = 0;
  localparam int RULE_B = 1;
  localparam int RULE_C = 2;

  typedef logic signed [STAMP_W-1:0] stamp_t;

  localparam stamp_t CLEAR_STAMP = -32'sd99000;

  localparam logic [COUNT_W-1:0] RESET_RULE_A_COUNT      = 8'd5;
  localparam logic [TIME_W-1:0]  RESET_RULE_A_WINDOW     = 31'd3000;
  localparam logic [COUNT_W-1:0] RESET_RULE_B_COUNT      = 8'd10;
  localparam logic [TIME_W-1:0]  RESET_RULE_B_WINDOW     = 31'd12000;
  localparam logic [COUNT_W-1:0] RESET_RULE_C_COUNT      = 8'd20;
  localparam logic [TIME_W-1:0]  RESET_RULE_C_WINDOW     = 31'd18000;
  localparam logic [TIME_W-1:0]  RESET_SILENCE_DURATION  = 31'd20000;

  typedef enum logic [2:0] {
    CFG_RULE_A_COUNT      = 3'd0,
    CFG_RULE_A_WINDOW     = 3'd1,
    CFG_RULE_B_COUNT      = 3'd2,
    CFG_RULE_B_WINDOW     = 3'd3,
    CFG_RULE_C_COUNT      = 3'd4,
    CFG_RULE_C_WINDOW     = 3'd5,
    CFG_SILENCE_DURATION  = 3'd6
  } cfg_idx_t;

  localparam logic FUNC_SAY   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] event_time;
  } in_req_t;

  typedef struct packed {
    logic flood_detected;
    logic silenced;
  } out_req_t;

  typedef struct packed {
    logic [NUM_RULES-1:0][COUNT_W-1:0] count;
    logic [NUM_RULES-1:0][TIME_W-1:0]  window;
    logic [TIME_W-1:0]                 silence_duration;
  } cfg_t;

endpackage

`default_nettype wire

### design/mwfl_cfg_regs.sv
`default_nettype none

module mwfl_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire mwfl_pkg::cfg_idx_t        cfg_addr,
  input  wire logic [mwfl_pkg::TIME_W-1:0] cfg_wdata,
  output mwfl_pkg::cfg_t                 cfg
);
  import mwfl_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_RULE_A_COUNT:     cfg_nxt.count[RULE_A]    = cfg_wdata[COUNT_W-1:0];
        CFG_RULE_A_WINDOW:    cfg_nxt.window[RULE_A]   = cfg_wdata;
        CFG_RULE_B_COUNT:     cfg_nxt.count[RULE_B]    = cfg_wdata[COUNT_W-1:0];
        CFG_RULE_B_WINDOW:    cfg_nxt.window[RULE_B]   = cfg_wdata;
        CFG_RULE_C_COUNT:     cfg_nxt.count[RULE_C]    = cfg_wdata[COUNT_W-1:0];
        CFG_RULE_C_WINDOW:    cfg_nxt.window[RULE_C]   = cfg_wdata;
        CFG_SILENCE_DURATION: cfg_nxt.silence_duration = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count[RULE_A]    <= RESET_RULE_A_COUNT;
      cfg_r.window[RULE_A]   <= RESET_RULE_A_WINDOW;
      cfg_r.count[RULE_B]    <= RESET_RULE_B_COUNT;
      cfg_r.window[RULE_B]   <= RESET_RULE_B_WINDOW;
      cfg_r.count[RULE_C]    <= RESET_RULE_C_COUNT;
      cfg_r.window[RULE_C]   <= RESET_RULE_C_WINDOW;
      cfg_r.silence_duration <= RESET_SILENCE_DURATION;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### design/mwfl_history.sv
`default_nettype none

module mwfl_history (
  input  wire logic                                                clk,
  input  wire logic                                                rst_n,
  input  wire logic                                                shift_en,
  input  wire logic                                                clear_en,
  input  wire mwfl_pkg::stamp_t                                    new_stamp,
  input  wire logic [mwfl_pkg::NUM_RULES-1:0][mwfl_pkg::COUNT_W-1:0] count,
  output mwfl_pkg::stamp_t [mwfl_pkg::NUM_RULES-1:0]               older
);
  import mwfl_pkg::*;

  // The history is a shift line with the newest stamp at tap zero, so the
  // stamp a given number of events back always sits at a fixed tap.
  stamp_t ring_r [HISTORY_DEPTH];
  stamp_t view   [HISTORY_DEPTH];
  logic [NUM_RULES-1:0][SLOT_W-1:0] sel;

  always_comb begin
    view[0] = new_stamp;
    for (int k = 1; k < HISTORY_DEPTH; k++) begin
      view[k] = ring_r[k-1];
    end
  end

  // A count of zero looks one place past the newest stamp, which wraps to
  // the oldest tap.
  always_comb begin
    for (int r = 0; r < NUM_RULES; r++) begin
      if (count[r] == '0) begin
        sel[r] = SLOT_W'(HISTORY_DEPTH - 1);
      end else begin
        sel[r] = SLOT_W'(count[r] - COUNT_W'(1));
      end
      older[r] = view[sel[r]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_en) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        ring_r[k] <= CLEAR_STAMP;
      end
    end else if (shift_en) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        ring_r[k] <= view[k];
      end
    end
  end

endmodule

`default_nettype wire

### design/mwfl_rules.sv
`default_nettype none

module mwfl_rules (
  input  wire logic [mwfl_pkg::TIME_W-1:0]           now,
  input  wire mwfl_pkg::stamp_t [mwfl_pkg::NUM_RULES-1:0] older,
  input  wire mwfl_pkg::cfg_t                        cfg,
  output logic                                       fire
);
  import mwfl_pkg::*;

  logic signed [STAMP_W:0]      diff   [NUM_RULES];
  logic        [NUM_RULES-1:0]  hit;

  always_comb begin
    for (int r = 0; r < NUM_RULES; r++) begin
      diff[r] = $signed({2'b00, now}) - $signed({older[r][STAMP_W-1], older[r]});
      hit[r]  = ({1'b0, cfg.count[r]} <= (COUNT_W+1)'(HISTORY_DEPTH)) &&
                (diff[r] < $signed({2'b00, cfg.window[r]}));
    end
    fire = |hit;
  end

endmodule

`default_nettype wire

### design/multi_window_flood_limiter_top.sv
`default_nettype none

// Flood limiter with three sliding-window rules over the last 32 event
// timestamps. A say request stores its timestamp and flags a flood when any
// rule sees its count of events within a span strictly shorter than its
// window; a flood sets a silence deadline of event_time plus the silence
// duration, and each result reports the flood flag and whether the deadline
// is still ahead. A clear request refills the history with a far-past stamp
// and keeps the deadline. The block takes one request every clock cycle while the
// output is not stalled; an accepted request waits in the input register, then
// the history taps, the three subtract-compares and the deadline update run
// combinationally into the result register. The history is a register shift
// line, so no memory port limits throughput. Configuration writes must be made
// while the block holds no request.
module multi_window_flood_limiter_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire mwfl_pkg::in_req_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output mwfl_pkg::out_req_t               out_data,
  input  wire logic                        cfg_we,
  input  wire mwfl_pkg::cfg_idx_t          cfg_addr,
  input  wire logic [mwfl_pkg::TIME_W-1:0] cfg_wdata
);
  import mwfl_pkg::*;

  cfg_t     cfg;
  stamp_t [NUM_RULES-1:0] older;
  logic     fire_any;

  logic     s1_valid_r, s1_valid_nxt;
  in_req_t  s1_data_r,  s1_data_nxt;
  logic     out_valid_r, out_valid_nxt;
  out_req_t out_data_r,  out_data_nxt;
  logic [STAMP_W-1:0] deadline_r, deadline_nxt;

  logic               out_ready;
  logic               s1_adv;
  logic               is_say;
  logic               fire;
  logic [STAMP_W-1:0] deadline_eff;

  mwfl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mwfl_history u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (s1_adv && is_say),
    .clear_en  (s1_adv && !is_say),
    .new_stamp ({1'b0, s1_data_r.event_time}),
    .count     (cfg.count),
    .older     (older)
  );

  mwfl_rules u_rules (
    .now   (s1_data_r.event_time),
    .older (older),
    .cfg   (cfg),
    .fire  (fire_any)
  );

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign is_say    = (s1_data_r.func == FUNC_SAY);
  assign fire      = is_say && fire_any;

  always_comb begin
    deadline_eff = deadline_r;
    if (fire) begin
      deadline_eff = {1'b0, s1_data_r.event_time} + {1'b0, cfg.silence_duration};
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_data_nxt  = s1_data_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
      if (in_valid) begin
        s1_data_nxt = in_data;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    deadline_nxt  = deadline_r;
    if (s1_adv) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.flood_detected = fire;
      out_data_nxt.silenced       = (deadline_eff > {1'b0, s1_data_r.event_time});
      deadline_nxt                = deadline_eff;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      deadline_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      deadline_r  <= deadline_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### design/mwfl_checker.sv
`default_nettype none

module mwfl_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire mwfl_pkg::in_req_t           in_data,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire mwfl_pkg::out_req_t          out_data
);

  // A stalled result is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A result appearing on an empty output came from a request accepted
  // earlier and held in the input register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching accepted request");

  // A clear request never reports a flood when it moves straight through.
  a_clear_no_flood: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.func == mwfl_pkg::FUNC_CLEAR) && !out_valid
    ##1 !out_stall |=> !(out_valid && out_data.flood_detected))
    else $error("clear request reported a flood");

endmodule

bind multi_window_flood_limiter_top mwfl_checker u_mwfl_checker (.*);

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import mwfl_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_req_t in_data;
  logic out_valid;
  logic out_stall;
  out_req_t out_data;
  logic cfg_we;
  cfg_idx_t cfg_addr;
  logic [TIME_W-1:0] cfg_wdata;

  logic [COUNT_W-1:0] rule_count [NUM_RULES];
  logic [TIME_W-1:0] rule_window [NUM_RULES];
  logic [TIME_W-1:0] quiet_span;
  stamp_t stamp_hist [HISTORY_DEPTH];
  int newest_slot;
  logic [STAMP_W-1:0] quiet_until;

  out_req_t verdict_q [$];
  int mismatch_count;
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold_request;
  int rx_hold_taken;
  int rx_wait;
  int rx_hold_left;
  int idle_cycles;

  multi_window_flood_limiter_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_history();
    for (int i = 0; i < HISTORY_DEPTH; i++) stamp_hist[i] = CLEAR_STAMP;
    newest_slot = 0;
  endfunction

  function automatic out_req_t apply_request(in_req_t req);
    out_req_t verdict;
    int look;
    longint span;
    logic [STAMP_W:0] sum;
    verdict = '0;
    if (req.func == FUNC_CLEAR) begin
      clear_history();
    end else begin
      newest_slot = (newest_slot == HISTORY_DEPTH - 1) ? 0 : newest_slot + 1;
      stamp_hist[newest_slot] = stamp_t'({1'b0, req.event_time});
      for (int r = 0; r < NUM_RULES; r++) begin
        if (int'(rule_count[r]) <= HISTORY_DEPTH) begin
          look = newest_slot - (int'(rule_count[r]) - 1);
          if (look < 0) look += HISTORY_DEPTH;
          if (look >= HISTORY_DEPTH) look -= HISTORY_DEPTH;
          span = longint'(stamp_hist[newest_slot]) - longint'(stamp_hist[look]);
          if (span < longint'(rule_window[r])) verdict.flood_detected = 1'b1;
        end
      end
      if (verdict.flood_detected) begin
        sum = {2'b00, req.event_time} + {2'b00, quiet_span};
        quiet_until = sum[STAMP_W] ? '1 : sum[STAMP_W-1:0];
      end
    end
    verdict.silenced = (quiet_until > {1'b0, req.event_time});
    return verdict;
  endfunction

  always @(posedge clk) begin
    out_req_t want;
    if (!rst_n) begin
      clear_history();
      quiet_until = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with no request pending, expected none actual %b",
                   $time, out_data);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data.flood_detected !== want.flood_detected) begin
            $display("%0t: flood_detected expected %0b actual %0b",
                     $time, want.flood_detected, out_data.flood_detected);
            mismatch_count++;
          end
          if (out_data.silenced !== want.silenced) begin
            $display("%0t: silenced expected %0b actual %0b",
                     $time, want.silenced, out_data.silenced);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) verdict_q.push_back(apply_request(in_data));
    end
  end

  always @(posedge clk) begin
    if (rx_hold_request != rx_hold_taken) begin
      rx_hold_taken = rx_hold_request;
      rx_hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else if (out_valid && !out_stall) begin
      rx_wait = rx_idle_on ? $urandom_range(0, 19) : 0;
      out_stall <= (rx_wait > 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= (rx_wait > 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_event(input logic kind, input logic [TIME_W-1:0] at);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{func: kind, event_time: at};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [TIME_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_RULE_A_COUNT: rule_count[RULE_A] = value[COUNT_W-1:0];
      CFG_RULE_A_WINDOW: rule_window[RULE_A] = value;
      CFG_RULE_B_COUNT: rule_count[RULE_B] = value[COUNT_W-1:0];
      CFG_RULE_B_WINDOW: rule_window[RULE_B] = value;
      CFG_RULE_C_COUNT: rule_count[RULE_C] = value[COUNT_W-1:0];
      CFG_RULE_C_WINDOW: rule_window[RULE_C] = value;
      CFG_SILENCE_DURATION: quiet_span = value;
      default: ;
    endcase
  endtask

  task automatic load_rules(input logic [TIME_W-1:0] count_a, window_a, count_b, window_b,
                            count_c, window_c, quiet);
    write_reg(CFG_RULE_A_COUNT, count_a);
    write_reg(CFG_RULE_A_WINDOW, window_a);
    write_reg(CFG_RULE_B_COUNT, count_b);
    write_reg(CFG_RULE_B_WINDOW, window_b);
    write_reg(CFG_RULE_C_COUNT, count_c);
    write_reg(CFG_RULE_C_WINDOW, window_c);
    write_reg(CFG_SILENCE_DURATION, quiet);
  endtask

  function automatic logic [TIME_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return TIME_W'($urandom_range(HISTORY_DEPTH + 1, 255));
      2: return TIME_W'(HISTORY_DEPTH);
      3: return 1;
      default: return TIME_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_window();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return TIME_MAX;
      default: return TIME_W'($urandom_range(0, 40000));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_quiet();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return TIME_MAX;
      2: return TIME_W'($urandom_range(0, TIME_MAX));
      default: return TIME_W'($urandom_range(0, 60000));
    endcase
  endfunction

  task automatic test_default_rules();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int t = 0; t < 5; t++) send_event(FUNC_SAY, TIME_W'(t));
    send_event(FUNC_SAY, TIME_MAX);
    // Time going backwards gives a negative span, which always fires.
    send_event(FUNC_SAY, 10);
    send_event(FUNC_CLEAR, 5);
    send_event(FUNC_CLEAR, TIME_MAX);
    send_event(FUNC_SAY, 0);
    wait_for_verdicts();
  endtask

  task automatic test_rule_extremes();
    // A count of one with a zero window never fires; a count of zero reads
    // the slot just after the newest one.
    load_rules(1, 0, 0, TIME_MAX, 255, TIME_MAX, TIME_MAX);
    send_event(FUNC_SAY, 100);
    send_event(FUNC_SAY, 100);
    send_event(FUNC_SAY, 200);
    wait_for_verdicts();
    // Counts above the depth never fire, and a zero silence ends at once.
    load_rules(1, 1, TIME_W'(HISTORY_DEPTH + 1), TIME_MAX, TIME_W'(HISTORY_DEPTH), 0, 0);
    send_event(FUNC_SAY, 300);
    send_event(FUNC_CLEAR, 300);
    send_event(FUNC_SAY, 0);
    wait_for_verdicts();
    load_rules(TIME_W'(HISTORY_DEPTH), TIME_MAX, 255, 0, 0, 0, TIME_MAX);
    send_event(FUNC_SAY, TIME_MAX);
    send_event(FUNC_SAY, TIME_MAX);
    send_event(FUNC_SAY, TIME_MAX - 1'b1);
    wait_for_verdicts();
  endtask

  task automatic test_backpressure();
    longint stamp;
    load_rules(4, 2500, 8, 9000, 16, 20000, 15000);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_request++;
    stamp = 1000;
    for (int k = 0; k < 40; k++) begin
      stamp += longint'($urandom_range(0, 1000));
      send_event(FUNC_SAY, stamp[TIME_W-1:0]);
    end
    wait_for_verdicts();
  endtask

  task automatic test_random_traffic();
    longint stamp;
    int step_max;
    int roll;
    for (int phase = 0; phase < 12; phase++) begin
      load_rules(pick_count(), pick_window(), pick_count(), pick_window(),
                 pick_count(), pick_window(), pick_quiet());
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1) stamp = longint'($urandom_range(0, TIME_MAX));
      else stamp = longint'($urandom_range(0, 100000));
      case ($urandom_range(0, 3))
        0: step_max = 50;
        1: step_max = 500;
        2: step_max = 3000;
        default: step_max = 20000;
      endcase
      for (int k = 0; k < 90; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          send_event(FUNC_CLEAR, stamp[TIME_W-1:0]);
        end else if (roll < 8) begin
          send_event(FUNC_SAY, TIME_W'($urandom_range(0, TIME_MAX)));
        end else begin
          stamp += longint'($urandom_range(0, step_max));
          if (stamp > longint'(TIME_MAX)) stamp = longint'(TIME_MAX);
          send_event(FUNC_SAY, stamp[TIME_W-1:0]);
        end
        if (phase == 6 && k == 45) wait_for_verdicts();
      end
      wait_for_verdicts();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_RULE_A_COUNT;
    cfg_wdata <= '0;
    rule_count[RULE_A] = RESET_RULE_A_COUNT;
    rule_window[RULE_A] = RESET_RULE_A_WINDOW;
    rule_count[RULE_B] = RESET_RULE_B_COUNT;
    rule_window[RULE_B] = RESET_RULE_B_WINDOW;
    rule_count[RULE_C] = RESET_RULE_C_COUNT;
    rule_window[RULE_C] = RESET_RULE_C_WINDOW;
    quiet_span = RESET_SILENCE_DURATION;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_rules();
    test_rule_extremes();
    test_backpressure();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, verdict_q.size());
    end
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
